@@ hw/rtl/assert_macros.svh @@
// assertion helpers for the rtl file that checks its own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// combinational check sampled at every rising clock edge outside reset
`define CHECK_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// implication check, antecedent and consequent written as one property
`define CHECK_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

@@ hw/rtl/btlv_pkg.sv @@
// ----------------------------------------------------------------------------
// btlv_pkg
// Types and constants shared by the BER TLV stream encoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package btlv_pkg;

  // operation codes
  localparam logic [1:0] OP_SET_POS = 2'd0;
  localparam logic [1:0] OP_HEADER  = 2'd1;
  localparam logic [1:0] OP_VALUE   = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_SPACE   = 2'd1;
  localparam logic [1:0] ST_UNEXPECTED = 2'd2;

  // tag and length form constants
  localparam logic [4:0]  TAG_MULTI_MARK = 5'h1F;
  localparam logic [31:0] LEN_LIM_1      = 32'h0000_007F;
  localparam logic [31:0] LEN_LIM_2      = 32'h0000_00FF;
  localparam logic [31:0] LEN_LIM_3      = 32'h0000_FFFF;
  localparam logic [31:0] LEN_LIM_4      = 32'h00FF_FFFF;
  localparam logic [7:0]  LEN_LONG_MARK  = 8'h80;

  localparam int MAX_HDR_BYTES = 7;

  // input transaction
  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] start_position;
    logic [15:0] tag;
    logic [31:0] value_length;
    logic [7:0]  value_byte;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic [31:0] byte_position;
    logic        last;
    logic [1:0]  status;
  } out_item_t;

  // classified work handed from front to back
  typedef struct packed {
    logic [MAX_HDR_BYTES-1:0][7:0] bytes;
    logic [2:0]                    count;
    logic [31:0]                   pos;
    logic                          byte_valid;
    logic [1:0]                    status;
  } job_t;

  // queue occupancy flags
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/btlv_front.sv @@
// ----------------------------------------------------------------------------
// btlv_front
// Accepts transactions, tracks write position and pending value bytes,
// checks capacity and builds one job per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module btlv_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [31:0]         cfg_wdata,
  input  wire logic                in_valid,
  input  wire btlv_pkg::in_item_t  in_data,
  input  wire btlv_pkg::q_status_t q_stat,
  output logic                     in_stall,
  output logic                     push,
  output btlv_pkg::job_t           push_job
);
  import btlv_pkg::*;

  logic [31:0] cap_r;
  logic [31:0] wp_r, wp_nxt;
  logic [31:0] vbl_r, vbl_nxt;
  logic        two_byte_tag;
  logic [2:0]  lsize;
  logic [2:0]  hdr_n;
  logic [4:0][7:0] lb;
  logic [MAX_HDR_BYTES-1:0][7:0] hdr;
  logic [33:0] need;

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  // length field size with the exact thresholds
  always_comb begin
    if (in_data.value_length < LEN_LIM_1) begin
      lsize = 3'd1;
    end else if (in_data.value_length < LEN_LIM_2) begin
      lsize = 3'd2;
    end else if (in_data.value_length < LEN_LIM_3) begin
      lsize = 3'd3;
    end else if (in_data.value_length < LEN_LIM_4) begin
      lsize = 3'd4;
    end else begin
      lsize = 3'd5;
    end
  end

  // length bytes, big-endian after the long-form mark
  always_comb begin
    lb = '0;
    case (lsize)
      3'd1: begin
        lb[0] = in_data.value_length[7:0];
      end
      3'd2: begin
        lb[0] = LEN_LONG_MARK | 8'd1;
        lb[1] = in_data.value_length[7:0];
      end
      3'd3: begin
        lb[0] = LEN_LONG_MARK | 8'd2;
        lb[1] = in_data.value_length[15:8];
        lb[2] = in_data.value_length[7:0];
      end
      3'd4: begin
        lb[0] = LEN_LONG_MARK | 8'd3;
        lb[1] = in_data.value_length[23:16];
        lb[2] = in_data.value_length[15:8];
        lb[3] = in_data.value_length[7:0];
      end
      default: begin
        lb[0] = LEN_LONG_MARK | 8'd4;
        lb[1] = in_data.value_length[31:24];
        lb[2] = in_data.value_length[23:16];
        lb[3] = in_data.value_length[15:8];
        lb[4] = in_data.value_length[7:0];
      end
    endcase
  end

  // tag bytes followed by length bytes
  assign two_byte_tag = (in_data.tag[12:8] == TAG_MULTI_MARK);
  assign hdr_n        = (two_byte_tag ? 3'd2 : 3'd1) + lsize;

  always_comb begin
    hdr = '0;
    if (two_byte_tag) begin
      hdr[0]   = in_data.tag[15:8];
      hdr[1]   = in_data.tag[7:0];
      hdr[6:2] = lb;
    end else begin
      hdr[0]   = in_data.tag[7:0];
      hdr[5:1] = lb;
    end
  end

  // whole element size against capacity, no wrap
  assign need = {2'b00, wp_r} + {31'd0, hdr_n} + {2'b00, in_data.value_length};

  // classify the transaction
  always_comb begin
    wp_nxt              = wp_r;
    vbl_nxt             = vbl_r;
    push_job            = '0;
    push_job.count      = 3'd1;
    push_job.pos        = wp_r;
    push_job.byte_valid = 1'b0;
    push_job.status     = ST_OK;
    case (in_data.operation)
      OP_SET_POS: begin
        wp_nxt       = in_data.start_position;
        vbl_nxt      = '0;
        push_job.pos = in_data.start_position;
      end
      OP_HEADER: begin
        if (need > {2'b00, cap_r}) begin
          vbl_nxt         = '0;
          push_job.status = ST_NO_SPACE;
        end else begin
          push_job.bytes      = hdr;
          push_job.count      = hdr_n;
          push_job.byte_valid = 1'b1;
          wp_nxt              = wp_r + {29'd0, hdr_n};
          vbl_nxt             = in_data.value_length;
        end
      end
      OP_VALUE: begin
        if (vbl_r == '0) begin
          push_job.status = ST_UNEXPECTED;
        end else if (wp_r >= cap_r) begin
          push_job.status = ST_NO_SPACE;
        end else begin
          push_job.bytes[0]   = in_data.value_byte;
          push_job.byte_valid = 1'b1;
          wp_nxt              = wp_r + 32'd1;
          vbl_nxt             = vbl_r - 32'd1;
        end
      end
      default: begin
        push_job.status = ST_OK;
      end
    endcase
  end

  // encoder state and capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= 32'd4096;
      wp_r  <= '0;
      vbl_r <= '0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (push) begin
        wp_r  <= wp_nxt;
        vbl_r <= vbl_nxt;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/btlv_queue.sv @@
// ----------------------------------------------------------------------------
// btlv_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module btlv_queue #(
  parameter int Depth = 4
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire btlv_pkg::job_t push_job,
  input  wire logic           pop,
  output btlv_pkg::job_t      pop_job,
  output btlv_pkg::q_status_t q_stat
);
  import btlv_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  job_t            mem [Depth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] cnt_r;

  assign q_stat.full  = (cnt_r == CntW'(Depth));
  assign q_stat.empty = (cnt_r == '0);
  assign pop_job      = mem[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/btlv_back.sv @@
// ----------------------------------------------------------------------------
// btlv_back
// Drains jobs into the output register, one result per cycle unless stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module btlv_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire btlv_pkg::job_t      pop_job,
  input  wire btlv_pkg::q_status_t q_stat,
  output logic                     pop,
  input  wire logic                out_stall,
  output logic                     out_valid,
  output btlv_pkg::out_item_t      out_data
);
  import btlv_pkg::*;

  job_t        cur_r;
  logic        cur_valid_r;
  logic [2:0]  idx_r;
  logic        out_valid_r;
  out_item_t   out_data_r;
  logic        load;
  logic        emit;
  logic        cur_last;

  assign load      = !out_valid_r || !out_stall;
  assign emit      = load && cur_valid_r;
  assign cur_last  = ((idx_r + 3'd1) == cur_r.count);
  assign pop       = !q_stat.empty && (!cur_valid_r || (emit && cur_last));
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // current job and byte index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (pop) begin
        cur_valid_r <= 1'b1;
        idx_r       <= '0;
      end else if (emit && cur_last) begin
        cur_valid_r <= 1'b0;
      end else if (emit) begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= pop_job;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= cur_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r.out_byte      <= cur_r.bytes[idx_r];
      out_data_r.byte_valid    <= cur_r.byte_valid;
      out_data_r.byte_position <= cur_r.pos + {29'd0, idx_r};
      out_data_r.last          <= cur_last;
      out_data_r.status        <= cur_r.status;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ber_tlv_stream_encoder_unit.sv @@
// ----------------------------------------------------------------------------
// ber_tlv_stream_encoder_unit
// BER TLV stream encoder: set position, tag/length header and value bytes
// written into a bounded buffer, one result per byte written or per status.
// ----------------------------------------------------------------------------
//  channel | direction | signals                 | moves
//  in      | input     | in_valid/in_stall       | one operation
//  out     | output    | out_valid/out_stall     | one byte or status
//  cfg     | input     | cfg_we/cfg_wdata        | buffer capacity
//
//  one transaction per cycle enters the front unless the queue is full; the
//  back emits one result per cycle unless stalled, so an n-byte header (2 to
//  7) takes n results. jobs pass the queue, current-job and output registers.
//  the queue (QueueDepth entries) absorbs header bursts; in_stall rises only
//  when it is full. synchronous reset sets capacity 4096, position 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ber_tlv_stream_encoder_unit #(
  parameter int QueueDepth = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [31:0]         cfg_wdata,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire btlv_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output btlv_pkg::out_item_t      out_data
);
  import btlv_pkg::*;

`include "assert_macros.svh"

  logic        push;
  logic        pop;
  job_t        push_job;
  job_t        pop_job;
  q_status_t   q_stat;
  logic        out_stat;
  logic        out_wr;
  logic        out_mid;
  logic [31:0] out_pos;
  logic [31:0] pos_inc;

  // classify and track state
  btlv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .in_stall  (in_stall),
    .push      (push),
    .push_job  (push_job)
  );

  // job queue
  btlv_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .q_stat   (q_stat)
  );

  // result drain
  btlv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_job   (pop_job),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // terms used by the checks
  assign out_stat = out_valid && !out_data.byte_valid;
  assign out_wr   = out_valid && out_data.byte_valid;
  assign out_mid  = out_valid && !out_stall && !out_data.last;
  assign out_pos  = out_data.byte_position;
  assign pos_inc  = out_data.byte_position + 32'd1;

  // checks
  `CHECK_ALWAYS(a_q_flags, !(q_stat.full && q_stat.empty), "queue full and empty at once")
  `CHECK_PROP(a_status_last, out_stat |-> out_data.last, "status result not last")
  `CHECK_PROP(a_byte_ok, out_wr |-> (out_data.status == ST_OK), "written byte with error status")
  `CHECK_PROP(a_hdr_seq, out_mid |=> (out_valid && out_pos == $past(pos_inc)), "byte gap in header")

endmodule

`default_nettype wire

@@ test/tb_ber_tlv_stream_encoder_unit.sv @@
// ----------------------------------------------------------------------------
// tb_ber_tlv_stream_encoder_unit
// Self-checking bench for the BER TLV stream encoder. A scoreboard class keeps
// its own copy of capacity, write position and pending value count, predicts
// every result byte and status of each accepted operation, and checks the
// result channel in order. Directed operations cover the length-form
// thresholds, one- and two-byte tags and every status case. Random phases
// over several capacities follow, mostly well-formed elements with some
// noise, with random input gaps and output stalls in all phases but one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ber_tlv_stream_encoder_unit;
  import btlv_pkg::*;

  // operation code that the block answers with an ok status and no write
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid  = 1'b0;
  in_item_t    in_data   = '0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  out_item_t   out_data;

  // no gaps or stalls while set
  logic calm = 1'b0;
  int   items_sent;
  int   stall_left;
  int   flow_left;

  // expected byte stream of the encoder
  class tlv_byte_scoreboard;
    logic [31:0] capacity;
    logic [31:0] wpos;
    logic [31:0] value_left;
    out_item_t   expected_bytes[$];
    int          errors;

    function new();
      capacity   = 32'd4096;
      wpos       = '0;
      value_left = '0;
      errors     = 0;
    endfunction

    function void set_capacity(logic [31:0] cap);
      capacity = cap;
    endfunction

    function int outstanding();
      return expected_bytes.size();
    endfunction

    function void push_byte(logic [7:0] b, logic valid, logic [31:0] pos, logic lst,
                            logic [1:0] st);
      out_item_t r;
      r.out_byte      = b;
      r.byte_valid    = valid;
      r.byte_position = pos;
      r.last          = lst;
      r.status        = st;
      expected_bytes.push_back(r);
    endfunction

    // predict the results of one accepted operation
    function void note_accepted(in_item_t it);
      logic [7:0]      hdr [MAX_HDR_BYTES];
      int              n;
      int              lsize;
      longint unsigned need;
      n = 0;
      case (it.operation)
        OP_SET_POS: begin
          wpos       = it.start_position;
          value_left = '0;
          push_byte(8'h00, 1'b0, wpos, 1'b1, ST_OK);
        end
        OP_HEADER: begin
          // tag, second byte only for the multi-byte mark
          if (it.tag[12:8] == TAG_MULTI_MARK) begin
            hdr[n] = it.tag[15:8];
            n++;
          end
          hdr[n] = it.tag[7:0];
          n++;
          // length form, each limit itself takes the longer form
          if (it.value_length < LEN_LIM_1) lsize = 1;
          else if (it.value_length < LEN_LIM_2) lsize = 2;
          else if (it.value_length < LEN_LIM_3) lsize = 3;
          else if (it.value_length < LEN_LIM_4) lsize = 4;
          else lsize = 5;
          if (lsize == 1) begin
            hdr[n] = it.value_length[7:0];
            n++;
          end else begin
            hdr[n] = LEN_LONG_MARK | 8'(lsize - 1);
            n++;
            for (int i = lsize - 1; i > 0; i--) begin
              hdr[n] = 8'(it.value_length >> (8 * (i - 1)));
              n++;
            end
          end
          // whole element must fit, no wrap
          need = 64'(wpos) + 64'(n) + 64'(it.value_length);
          if (need > 64'(capacity)) begin
            value_left = '0;
            push_byte(8'h00, 1'b0, wpos, 1'b1, ST_NO_SPACE);
          end else begin
            for (int i = 0; i < n; i++)
              push_byte(hdr[i], 1'b1, wpos + 32'(i), i == n - 1, ST_OK);
            wpos       = wpos + 32'(n);
            value_left = it.value_length;
          end
        end
        OP_VALUE: begin
          if (value_left == 0) begin
            push_byte(8'h00, 1'b0, wpos, 1'b1, ST_UNEXPECTED);
          end else if (wpos >= capacity) begin
            push_byte(8'h00, 1'b0, wpos, 1'b1, ST_NO_SPACE);
          end else begin
            push_byte(it.value_byte, 1'b1, wpos, 1'b1, ST_OK);
            wpos       = wpos + 32'd1;
            value_left = value_left - 32'd1;
          end
        end
        default: begin
          push_byte(8'h00, 1'b0, wpos, 1'b1, ST_OK);
        end
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    // compare one result transaction with the oldest expectation
    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_bytes.size() == 0) begin
        $error("result with nothing expected: byte %0h pos %0h status %0d",
               got.out_byte, got.byte_position, got.status);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      compare_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
      compare_field("byte_valid", 32'(want.byte_valid), 32'(got.byte_valid));
      compare_field("byte_position", want.byte_position, got.byte_position);
      compare_field("last", 32'(want.last), 32'(got.last));
      compare_field("status", 32'(want.status), 32'(got.status));
    endfunction
  endclass

  tlv_byte_scoreboard sb = new();

  ber_tlv_stream_encoder_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // clock
  always #5 clk = ~clk;

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side: check accepted transactions, stall at random
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && !out_stall) sb.check_result(out_data);
      if (flow_left > 0) begin
        flow_left--;
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        flow_left  = $urandom_range(0, 10);
        stall_left = pick_gap();
        out_stall <= 1'b0;
      end
    end
  end

  // run limit
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic in_item_t make_item(logic [1:0] op, logic [31:0] pos, logic [15:0] tg,
                                         logic [31:0] len, logic [7:0] b);
    in_item_t it;
    it.operation      = op;
    it.start_position = pos;
    it.tag            = tg;
    it.value_length   = len;
    it.value_byte     = b;
    return it;
  endfunction

  task automatic idle_sender();
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // drive one transaction and hold it until accepted
  task automatic send_item(input in_item_t it);
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_accepted(it);
    items_sent++;
    idle_sender();
  endtask

  task automatic put_set_pos(input logic [31:0] pos);
    send_item(make_item(OP_SET_POS, pos, 16'($urandom()), $urandom(), 8'($urandom())));
  endtask

  task automatic put_header(input logic [15:0] tg, input logic [31:0] len);
    send_item(make_item(OP_HEADER, $urandom(), tg, len, 8'($urandom())));
  endtask

  task automatic put_value(input logic [7:0] b);
    send_item(make_item(OP_VALUE, $urandom(), 16'($urandom()), $urandom(), b));
  endtask

  task automatic put_raw(input logic [1:0] op);
    send_item(make_item(op, $urandom(), 16'($urandom()), $urandom(), 8'($urandom())));
  endtask

  // hold off the sender until every expected result is back
  task automatic wait_all_done();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [31:0] cap);
    cfg_wdata <= cap;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_capacity(cap);
  endtask

  function automatic logic [31:0] pick_position();
    int          r;
    logic [31:0] cap;
    r   = $urandom_range(0, 99);
    cap = sb.capacity;
    if (r < 50) return $urandom_range(0, 64);
    if (r < 80) return (cap >= 40) ? cap - $urandom_range(0, 40) : $urandom_range(0, 8);
    return $urandom();
  endfunction

  // one element: optional position, header, value bytes (sometimes broken)
  task automatic random_element();
    logic [15:0] tg;
    logic [31:0] len;
    int          nval;
    int          r;
    if ($urandom_range(0, 99) < 30) put_set_pos(pick_position());
    tg = 16'($urandom());
    if ($urandom_range(0, 1) == 1) tg[12:8] = TAG_MULTI_MARK;
    r = $urandom_range(0, 99);
    if (r < 88) begin
      len = $urandom_range(0, 12);
      if (r < 70) nval = len;
      else if (r < 80) nval = (len > 0) ? $urandom_range(0, len - 1) : 0;
      else nval = len + 1;
    end else begin
      // around a length-form limit
      case ($urandom_range(0, 4))
        0: len = LEN_LIM_1;
        1: len = LEN_LIM_2;
        2: len = LEN_LIM_3;
        3: len = LEN_LIM_4;
        default: len = 32'hFFFF_FFFF;
      endcase
      len  = len + $urandom_range(0, 2) - 1;
      nval = $urandom_range(0, 5);
    end
    put_header(tg, len);
    repeat (nval) put_value(8'($urandom()));
  endtask

  task automatic random_phase(input logic [31:0] cap, input int quota);
    int stop;
    wait_all_done();
    write_capacity(cap);
    stop = items_sent + quota;
    while (items_sent < stop) begin
      if ($urandom_range(0, 99) < 80) random_element();
      else put_raw(2'($urandom_range(0, 3)));
      if ($urandom_range(0, 59) == 0) wait_all_done();
    end
  endtask

  // main sequence
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset capacity, status cases
    put_raw(OP_UNUSED);
    put_value(8'hA5);
    put_set_pos(32'd4090);
    put_header(16'h0004, 32'd10);
    put_value(8'h00);
    put_header(16'h0004, 32'd4);
    put_value(8'hFF);

    // value byte once the capacity is below the write position
    wait_all_done();
    write_capacity(32'd4092);
    put_value(8'h5A);

    // short and long forms, two-byte tags, header over pending bytes
    wait_all_done();
    write_capacity(32'd4096);
    put_set_pos(32'd0);
    put_header(16'h0030, 32'd0);
    put_header(16'hBF25, 32'h7E);
    put_value(8'h00);
    put_value(8'hFF);
    put_header(16'hFFFF, 32'h7F);
    put_header(16'h0E01, 32'hFE);
    put_header(16'h1F00, 32'hFF);

    // widest lengths and the top of the position range
    wait_all_done();
    write_capacity(32'hFFFF_FFFF);
    put_set_pos(32'd0);
    put_header(16'h3F8A, 32'hFFFE);
    put_header(16'h0002, 32'hFFFF);
    put_header(16'h0002, 32'hFF_FFFE);
    put_header(16'hDFFF, 32'hFF_FFFF);
    put_header(16'h0002, 32'hFFFF_FFFF);
    put_set_pos(32'hFFFF_FFF0);
    put_header(16'h0005, 32'd8);
    put_value(8'h11);
    put_set_pos(32'hFFFF_FFFF);
    put_header(16'h0005, 32'd0);

    // empty buffer
    wait_all_done();
    write_capacity(32'd0);
    put_set_pos(32'd0);
    put_header(16'h0000, 32'd0);
    put_value(8'h80);

    // random phases over several capacities
    random_phase(32'd4096, 80);
    random_phase(32'($urandom_range(24, 300)), 80);
    calm = 1'b1;
    random_phase(32'hFFFF_FFFF, 80);
    calm = 1'b0;
    random_phase($urandom(), 80);
    random_phase(32'd0, 20);
    random_phase(32'($urandom_range(1, 8)), 80);

    wait_all_done();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
